// ===== hdl/tpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tpf_pkg
// Types, constants and the CRC-16/CCITT-FALSE byte update for the telemetry
// packet framer.
// ----------------------------------------------------------------------------
package tpf_pkg;

    localparam int PAYLOAD_BYTES_DEF = 17;
    localparam int POS_W             = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  BYTE_CR  = 8'h0D;
    localparam logic [7:0]  BYTE_LF  = 8'h0A;

    // Input request fields
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  msg_id_first;
        logic [7:0]  msg_id_second;
        logic [31:0] time_ms;
    } in_t;

    // Result fields
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       packet_end;
    } out_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic [31:0] seq;
        in_t         data;
    } cmd_t;

    // Position of a byte inside a framed packet
    typedef enum logic [3:0] {
        STEP_MARKER  = 4'd0,
        STEP_SEQ3    = 4'd1,
        STEP_SEQ2    = 4'd2,
        STEP_SEQ1    = 4'd3,
        STEP_SEQ0    = 4'd4,
        STEP_ID_A    = 4'd5,
        STEP_ID_B    = 4'd6,
        STEP_TIME3   = 4'd7,
        STEP_TIME2   = 4'd8,
        STEP_TIME1   = 4'd9,
        STEP_TIME0   = 4'd10,
        STEP_PAYLOAD = 4'd11,
        STEP_CRC_HI  = 4'd12,
        STEP_CRC_LO  = 4'd13,
        STEP_CR      = 4'd14,
        STEP_LF      = 4'd15
    } step_t;

    // Fold one byte into the CRC, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/tpf_front.sv =====
// ----------------------------------------------------------------------------
// tpf_front
// Accepts payload requests, tracks the packet position and sequence number,
// and classifies each request as first and/or last of its packet.
// ----------------------------------------------------------------------------
module tpf_front #(
    parameter int PAYLOAD_BYTES = tpf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tpf_pkg::in_t  s_data,
    input  logic          q_full,
    output logic          q_push,
    output tpf_pkg::cmd_t q_cmd
);

    localparam logic [tpf_pkg::POS_W-1:0] LAST_POS = tpf_pkg::POS_W'(PAYLOAD_BYTES - 1);

    logic [tpf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [31:0]               seq_reg, seq_next;
    logic                      is_first, is_last;

    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;
    assign is_first = (pos_reg == '0);
    assign is_last  = (pos_reg == LAST_POS);

    // Build the classified request
    always_comb begin
        q_cmd.first = is_first;
        q_cmd.last  = is_last;
        q_cmd.seq   = seq_reg;
        q_cmd.data  = s_data;
    end

    // Advance position on each accepted request, and the sequence on a packet's first
    always_comb begin
        pos_next = pos_reg;
        seq_next = seq_reg;
        if (q_push) begin
            pos_next = is_last ? '0 : pos_reg + tpf_pkg::POS_W'(1);
            if (is_first) begin
                seq_next = seq_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            seq_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            seq_reg <= seq_next;
        end
    end

endmodule

// ===== hdl/tpf_queue.sv =====
// ----------------------------------------------------------------------------
// tpf_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module tpf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tpf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output tpf_pkg::cmd_t head_cmd
);

    tpf_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/tpf_back.sv =====
// ----------------------------------------------------------------------------
// tpf_back
// Sequences the bytes of each classified request onto the result stream,
// one byte a cycle while the result channel is not stalled, and keeps the running CRC.
// ----------------------------------------------------------------------------
module tpf_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    start_marker,
    input  logic          q_valid,
    input  tpf_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output tpf_pkg::out_t m_data
);

    tpf_pkg::cmd_t  cur_reg, cur_next;
    logic           cur_valid_reg, cur_valid_next;
    tpf_pkg::step_t step_reg, step_next;
    logic [15:0]    crc_reg, crc_next;
    logic           m_valid_reg, m_valid_next;
    tpf_pkg::out_t  m_data_reg, m_data_next;

    logic           emit, at_end, load, hashed;
    logic [7:0]     cur_byte;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign emit   = cur_valid_reg && (!m_valid_reg || m_ready);
    assign at_end = (step_reg == tpf_pkg::STEP_LF)
                 || (step_reg == tpf_pkg::STEP_PAYLOAD && !cur_reg.last);
    assign load   = q_valid && (!cur_valid_reg || (emit && at_end));
    assign q_pop  = load;
    assign hashed = (step_reg <= tpf_pkg::STEP_PAYLOAD);

    // Select the byte for the current step
    always_comb begin
        cur_byte = 8'h00;
        unique case (step_reg)
            tpf_pkg::STEP_MARKER:  cur_byte = start_marker;
            tpf_pkg::STEP_SEQ3:    cur_byte = cur_reg.seq[31:24];
            tpf_pkg::STEP_SEQ2:    cur_byte = cur_reg.seq[23:16];
            tpf_pkg::STEP_SEQ1:    cur_byte = cur_reg.seq[15:8];
            tpf_pkg::STEP_SEQ0:    cur_byte = cur_reg.seq[7:0];
            tpf_pkg::STEP_ID_A:    cur_byte = cur_reg.data.msg_id_first;
            tpf_pkg::STEP_ID_B:    cur_byte = cur_reg.data.msg_id_second;
            tpf_pkg::STEP_TIME3:   cur_byte = cur_reg.data.time_ms[31:24];
            tpf_pkg::STEP_TIME2:   cur_byte = cur_reg.data.time_ms[23:16];
            tpf_pkg::STEP_TIME1:   cur_byte = cur_reg.data.time_ms[15:8];
            tpf_pkg::STEP_TIME0:   cur_byte = cur_reg.data.time_ms[7:0];
            tpf_pkg::STEP_PAYLOAD: cur_byte = cur_reg.data.payload_byte;
            tpf_pkg::STEP_CRC_HI:  cur_byte = crc_reg[15:8];
            tpf_pkg::STEP_CRC_LO:  cur_byte = crc_reg[7:0];
            tpf_pkg::STEP_CR:      cur_byte = tpf_pkg::BYTE_CR;
            tpf_pkg::STEP_LF:      cur_byte = tpf_pkg::BYTE_LF;
        endcase
    end

    // Advance the sequencer, CRC and output register
    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        crc_next       = crc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        if (emit) begin
            m_valid_next          = 1'b1;
            m_data_next.out_byte  = cur_byte;
            m_data_next.run_last  = at_end;
            m_data_next.packet_end = (step_reg == tpf_pkg::STEP_LF);
            if (hashed) begin
                crc_next = tpf_pkg::crc_feed(
                    (step_reg == tpf_pkg::STEP_MARKER) ? tpf_pkg::CRC_INIT : crc_reg,
                    cur_byte);
            end
            if (at_end) begin
                cur_valid_next = 1'b0;
            end else begin
                step_next = tpf_pkg::step_t'(step_reg + 4'd1);
            end
        end

        // Take the next request from the queue
        if (load) begin
            cur_next       = q_cmd;
            cur_valid_next = 1'b1;
            step_next      = q_cmd.first ? tpf_pkg::STEP_MARKER : tpf_pkg::STEP_PAYLOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= tpf_pkg::STEP_MARKER;
            crc_reg       <= tpf_pkg::CRC_INIT;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            crc_reg       <= crc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hdl/telemetry_packet_framer_core.sv =====
// ----------------------------------------------------------------------------
// telemetry_packet_framer_core
// Frames payload bytes into telemetry packets with header, CRC-16 and CR LF.
//
//   channel   ports                          moves
//   input     s_valid s_ready s_data         one payload byte + header fields
//   result    m_valid m_ready m_data         one framed byte
//   config    cfg_valid cfg_ready cfg_data   start marker byte
//
// The back end sends one byte per cycle unless the result channel stalls:
// 12 bytes for a packet's first request, 1 for a middle one, 5 for the last
// (16 when a packet holds one byte); the single output byte port sets this.
// The front takes a request every cycle while the two-entry queue has room.
// Reset (aresetn low, synchronous) clears position, sequence, CRC, queue and
// output valid; the start marker resets to zero. cfg_ready is always high.
// ----------------------------------------------------------------------------
module telemetry_packet_framer_core #(
    parameter int PAYLOAD_BYTES = tpf_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tpf_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tpf_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);

    logic [7:0]    marker_reg, marker_next;
    logic          q_push, q_full, q_pop, q_valid;
    tpf_pkg::cmd_t q_in, q_head;

    assign cfg_ready = 1'b1;

    // Hold the start marker
    assign marker_next = cfg_valid ? cfg_data : marker_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= 8'h00;
        end else begin
            marker_reg <= marker_next;
        end
    end

    tpf_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_in)
    );

    tpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    tpf_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_marker (marker_reg),
        .q_valid      (q_valid),
        .q_cmd        (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telemetry packet framer core. A behavioral
// framer tracks sequence number, running CRC-16 and payload position, builds
// the framed bytes owed for every accepted payload request and checks each
// byte on the result channel in order. Directed packets cover field extremes,
// the header fields being ignored after a packet's first byte and both ends
// of the start marker; random phases add traffic, all but one under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAME_PAYLOAD = tpf_pkg::PAYLOAD_BYTES_DEF;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 33;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    tpf_pkg::in_t  s_data    = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    tpf_pkg::out_t m_data;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_data  = 8'h00;

    // Behavioral framer state
    logic [31:0] next_seq;
    logic [15:0] frame_crc;
    logic [5:0]  frame_pos;
    logic [7:0]  start_marker;

    tpf_pkg::out_t framed_bytes_due[$];
    tpf_pkg::out_t staged_bytes[$];

    bit quiet_source;
    bit quiet_sink;
    int error_count;
    int cycle_count;
    int requests_sent;
    int bytes_checked;
    int packets_seen;
    int marker_writes;

    telemetry_packet_framer_core #(
        .PAYLOAD_BYTES(FRAME_PAYLOAD)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Fold one byte into the CRC, one bit at a time from the MSB
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? tpf_pkg::CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    // Stage one framed byte, optionally folding it into the CRC
    task automatic stage_byte(input logic [7:0] b, input bit hashed, input bit is_end);
        tpf_pkg::out_t r;
        r.out_byte   = b;
        r.run_last   = 1'b0;
        r.packet_end = is_end;
        staged_bytes.push_back(r);
        if (hashed) begin
            frame_crc = crc16_next(frame_crc, b);
        end
    endtask

    // Build the bytes owed for one accepted payload request
    task automatic frame_request(input tpf_pkg::in_t req);
        logic [15:0]   crc_snap;
        tpf_pkg::out_t r;
        staged_bytes.delete();
        if (frame_pos == 6'd0) begin
            frame_crc = tpf_pkg::CRC_INIT;
            stage_byte(start_marker, 1'b1, 1'b0);
            for (int i = 3; i >= 0; i--) begin
                stage_byte(next_seq[8*i +: 8], 1'b1, 1'b0);
            end
            next_seq = next_seq + 32'd1;
            stage_byte(req.msg_id_first, 1'b1, 1'b0);
            stage_byte(req.msg_id_second, 1'b1, 1'b0);
            for (int i = 3; i >= 0; i--) begin
                stage_byte(req.time_ms[8*i +: 8], 1'b1, 1'b0);
            end
        end
        stage_byte(req.payload_byte, 1'b1, 1'b0);
        frame_pos = frame_pos + 6'd1;
        // Close the packet: CRC high then low, CR, LF
        if (frame_pos >= FRAME_PAYLOAD || frame_pos == 6'd0) begin
            crc_snap = frame_crc;
            stage_byte(crc_snap[15:8], 1'b0, 1'b0);
            stage_byte(crc_snap[7:0], 1'b0, 1'b0);
            stage_byte(tpf_pkg::BYTE_CR, 1'b0, 1'b0);
            stage_byte(tpf_pkg::BYTE_LF, 1'b0, 1'b1);
            frame_pos = 6'd0;
            frame_crc = tpf_pkg::CRC_INIT;
        end
        // Mark the last byte of this request and queue them all
        for (int i = 0; i < staged_bytes.size(); i++) begin
            r = staged_bytes[i];
            r.run_last = (i == staged_bytes.size() - 1);
            framed_bytes_due.push_back(r);
        end
    endtask

    // Track config and input requests, then check each result byte
    always @(posedge aclk) begin
        tpf_pkg::out_t want;
        if (!aresetn) begin
            next_seq     = 32'd0;
            frame_crc    = tpf_pkg::CRC_INIT;
            frame_pos    = 6'd0;
            start_marker = 8'h00;
            framed_bytes_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                start_marker = cfg_data;
            end
            if (s_valid && s_ready) begin
                frame_request(s_data);
            end
            if (m_valid && m_ready) begin
                if (framed_bytes_due.size() == 0) begin
                    $display("%0t: unexpected byte: expected none, actual %02h last %b end %b",
                             $time, m_data.out_byte, m_data.run_last, m_data.packet_end);
                    error_count++;
                end else begin
                    want = framed_bytes_due.pop_front();
                    bytes_checked++;
                    if (m_data.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.out_byte, m_data.out_byte);
                        error_count++;
                    end
                    if (m_data.run_last !== want.run_last) begin
                        $display("%0t: run_last mismatch: expected %b, actual %b",
                                 $time, want.run_last, m_data.run_last);
                        error_count++;
                    end
                    if (m_data.packet_end !== want.packet_end) begin
                        $display("%0t: packet_end mismatch: expected %b, actual %b",
                                 $time, want.packet_end, m_data.packet_end);
                        error_count++;
                    end
                    if (want.packet_end) begin
                        packets_seen++;
                    end
                end
            end
        end
    end

    // Drive result back-pressure
    always @(posedge aclk) begin
        m_ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes outstanding", $time,
                     framed_bytes_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one payload request and hold it until accepted
    task automatic send_request(input tpf_pkg::in_t req);
        int gap;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        gap = 0;
        while (!quiet_source && gap < 8 && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, wait for every owed byte, then let the core settle
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (framed_bytes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the start marker register
    task automatic write_marker(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        marker_writes++;
        @(posedge aclk);
    endtask

    function automatic tpf_pkg::in_t random_request();
        tpf_pkg::in_t req;
        req.payload_byte  = 8'($urandom);
        req.msg_id_first  = 8'($urandom);
        req.msg_id_second = 8'($urandom);
        req.time_ms       = $urandom;
        return req;
    endfunction

    // One full packet at the reset marker; header fields vary after byte one
    task automatic test_reset_marker_packet();
        tpf_pkg::in_t req;
        logic [7:0] pattern [15] = '{8'h00, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE,
                                     8'h0D, 8'h0A, 8'hFF, 8'h00, 8'h3C, 8'hC3, 8'h10,
                                     8'hEF};
        req.payload_byte  = 8'hFF;
        req.msg_id_first  = 8'hFF;
        req.msg_id_second = 8'hFF;
        req.time_ms       = 32'hFFFF_FFFF;
        send_request(req);
        for (int i = 0; i < 15; i++) begin
            req = random_request();
            req.payload_byte = pattern[i];
            send_request(req);
        end
        req.payload_byte  = 8'h00;
        req.msg_id_first  = 8'hA5;
        req.msg_id_second = 8'h5A;
        req.time_ms       = 32'h1234_5678;
        send_request(req);
        wait_for_idle();
    endtask

    // Top marker value with all-zero header fields; random traffic ends the packet
    task automatic test_marker_extremes();
        tpf_pkg::in_t req;
        write_marker(8'hFF);
        req.payload_byte  = 8'h00;
        req.msg_id_first  = 8'h00;
        req.msg_id_second = 8'h00;
        req.time_ms       = 32'h0000_0000;
        send_request(req);
        req.payload_byte = 8'hFF;
        send_request(req);
        req.payload_byte = 8'h80;
        send_request(req);
        req.payload_byte = 8'h01;
        send_request(req);
        wait_for_idle();
    endtask

    // Random payload traffic at one marker setting
    task automatic test_random_phase(input logic [7:0] marker, input int count, input bit quiet);
        wait_for_idle();
        write_marker(marker);
        quiet_source = quiet;
        quiet_sink   = quiet;
        for (int i = 0; i < count; i++) begin
            send_request(random_request());
        end
        wait_for_idle();
        quiet_source = 1'b0;
        quiet_sink   = 1'b0;
    endtask

    initial begin
        quiet_source = 1'b0;
        quiet_sink   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_marker_packet();
        test_marker_extremes();
        test_random_phase(8'h00, 95, 1'b0);
        test_random_phase(8'hFF, 95, 1'b1);
        test_random_phase(8'($urandom), 95, 1'b0);
        test_random_phase(8'($urandom), 95, 1'b0);

        $display("Sent %0d payload requests, checked %0d framed bytes in %0d packets.",
                 requests_sent, bytes_checked, packets_seen);
        $display("Start marker written %0d times, including 0x00 and 0xFF.", marker_writes);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tpf_pkg.sv
hdl/tpf_front.sv
hdl/tpf_queue.sv
hdl/tpf_back.sv
hdl/telemetry_packet_framer_core.sv
test/tb_top.sv
